// File: src/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Shared widths, byte constants and the control/status bundles of the API
// frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 7;
	localparam int IDX_W      = 6;
	localparam int M_TDATA_W  = 24;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
	localparam logic [BYTE_W-1:0] GOOD_SUM   = 8'hFF;

	// controller to datapath
	typedef struct packed {
		logic len_hi_ld;   // length high byte taken
		logic len_lo_ld;   // length low byte taken, clear count and sum
		logic pay_wr;      // payload byte stored
		logic play_start;  // checksum good, rewind playout index
		logic rd_en;       // read buffer at playout index
		logic out_ld;      // move read data into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sof;         // input byte is the start delimiter
		logic len_over;    // length above buffer size
		logic len_zero;    // length is zero
		logic pay_done;    // this payload byte is the last one
		logic sum_good;    // checksum byte completes a good sum
		logic play_last;   // current playout word is the final one
		logic out_free;    // output register can take a word
	} sts_t;

endpackage

// File: src/afr_ctrl.sv
// ----------------------------------------------------------------------------
// afr_ctrl
// Frame parsing state machine: hunts, reads length, payload and checksum,
// then sequences the playout of a verified frame.
// ----------------------------------------------------------------------------
module afr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  afr_pkg::sts_t sts,
	output afr_pkg::cmd_t cmd
);
	import afr_pkg::*;

	localparam logic [2:0] ST_HUNT     = 3'd0;
	localparam logic [2:0] ST_LEN_HI   = 3'd1;
	localparam logic [2:0] ST_LEN_LO   = 3'd2;
	localparam logic [2:0] ST_PAYLOAD  = 3'd3;
	localparam logic [2:0] ST_CHECK    = 3'd4;
	localparam logic [2:0] ST_PLAY_RD  = 3'd5;
	localparam logic [2:0] ST_PLAY_OUT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       acc;

	assign s_tready = (state_q == ST_HUNT) || (state_q == ST_LEN_HI) ||
	                  (state_q == ST_LEN_LO) || (state_q == ST_PAYLOAD) ||
	                  (state_q == ST_CHECK);
	assign acc = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_HUNT: begin
				if (acc && sts.sof) state_d = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				if (acc) begin
					cmd.len_hi_ld = 1'b1;
					state_d       = ST_LEN_LO;
				end
			end
			ST_LEN_LO: begin
				if (acc) begin
					cmd.len_lo_ld = 1'b1;
					if (sts.len_over)      state_d = ST_HUNT;
					else if (sts.len_zero) state_d = ST_CHECK;
					else                   state_d = ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				if (acc) begin
					cmd.pay_wr = 1'b1;
					if (sts.pay_done) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (acc) begin
					if (sts.sum_good) begin
						cmd.play_start = 1'b1;
						state_d        = ST_PLAY_RD;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_PLAY_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_PLAY_OUT;
			end
			ST_PLAY_OUT: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = sts.play_last ? ST_HUNT : ST_PLAY_RD;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// a word is only loaded when the output register can take it
	a_out_ld_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("output register overwritten");

	// every buffer read is followed by its output step
	a_rd_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> (state_q == ST_PLAY_OUT))
		else $error("buffer read without output step");

	// no input taken while a frame plays out
	a_no_input_in_play: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en || cmd.out_ld || !sts.out_free && state_q == ST_PLAY_OUT)
		|-> !s_tready)
		else $error("input accepted during playout");

endmodule

// File: src/afr_datapath.sv
// ----------------------------------------------------------------------------
// afr_datapath
// Length capture, payload buffer, running sum, playout index and the
// output register of the API frame receiver.
// ----------------------------------------------------------------------------
module afr_datapath #(
	parameter int MAX_FRAME = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [afr_pkg::BYTE_W-1:0] rx_byte,
	input  afr_pkg::cmd_t              cmd,
	output afr_pkg::sts_t              sts,
	input  logic                       m_tready,
	output logic                       m_tvalid,
	output logic [afr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);
	import afr_pkg::*;

	localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_FRAME);

	logic [BYTE_W-1:0] store [0:MAX_FRAME-1];

	logic              hi_nz_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  count_q;
	logic [BYTE_W-1:0] sum_q;
	logic [LEN_W-1:0]  play_idx_q;
	logic [BYTE_W-1:0] rdata_q;

	logic              m_tvalid_q;
	logic [BYTE_W-1:0] frame_byte_q;
	logic [IDX_W-1:0]  byte_index_q;
	logic [LEN_W-1:0]  frame_length_q;
	logic              empty_q;
	logic              last_q;

	logic              play_last;
	logic [BYTE_W-1:0] sum_chk;

	assign sum_chk   = sum_q + rx_byte;
	assign play_last = (length_q == '0) || (play_idx_q + LEN_W'(1) >= length_q);

	assign sts.sof       = (rx_byte == START_BYTE);
	assign sts.len_over  = hi_nz_q || (rx_byte > MAX_LEN);
	assign sts.len_zero  = (rx_byte == '0);
	assign sts.pay_done  = (count_q + LEN_W'(1) >= length_q);
	assign sts.sum_good  = (sum_chk == GOOD_SUM);
	assign sts.play_last = play_last;
	assign sts.out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_nz_q    <= 1'b0;
			length_q   <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			play_idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.len_hi_ld) hi_nz_q <= (rx_byte != '0);
			if (cmd.len_lo_ld) begin
				length_q <= rx_byte[LEN_W-1:0];
				count_q  <= '0;
				sum_q    <= '0;
			end
			if (cmd.pay_wr) begin
				count_q <= count_q + LEN_W'(1);
				sum_q   <= sum_q + rx_byte;
			end
			if (cmd.play_start) play_idx_q <= '0;
			else if (cmd.out_ld) play_idx_q <= play_idx_q + LEN_W'(1);
			if (cmd.out_ld) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// payload buffer, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.pay_wr) store[count_q[AW-1:0]] <= rx_byte;
		if (cmd.rd_en) rdata_q <= store[play_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			frame_byte_q   <= (length_q == '0) ? '0 : rdata_q;
			byte_index_q   <= play_idx_q[IDX_W-1:0];
			frame_length_q <= length_q;
			empty_q        <= (length_q == '0);
			last_q         <= play_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, frame_length_q, byte_index_q, frame_byte_q};
	assign m_tlast  = last_q;
	assign m_tuser  = empty_q;

	// an empty frame leaves as a single word marked last
	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld && (length_q == '0) |=> m_tvalid && m_tuser && m_tlast)
		else $error("empty frame word malformed");

endmodule

// File: src/api_frame_receiver.sv
// ----------------------------------------------------------------------------
// api_frame_receiver
// Receives serial bytes, parses API frames (start delimiter, 16-bit length,
// payload, checksum) and plays each verified frame out as a run of words.
//
//  channel  dir  signals                          word
//  s_*      in   s_tvalid s_tready s_tdata[7:0]   one received byte
//  m_*      out  m_tvalid m_tready m_tdata m_tlast m_tuser  one payload byte
//
// One received byte per cycle while parsing. A good checksum starts a
// playout in which each result word is a buffer read, then an output load,
// with input held off until the frame's last word is in the output register.
// An empty frame gives a single word. m_tready low stalls the playout only;
// the output register lets parsing resume while its last word waits.
// arst_n clears the parser to hunting and empties the output register; the
// payload buffer needs no clearing.
// ----------------------------------------------------------------------------
module api_frame_receiver #(
	parameter int MAX_FRAME = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_index, [20:14] frame_length
	output logic        m_tlast,   // last
	output logic        m_tuser    // empty_frame
);
	import afr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	afr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	afr_datapath #(
		.MAX_FRAME (MAX_FRAME)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
